[src/assert_macros.svh]
// Assertion macros used by the top level of the type classifier.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/sqltk_pkg.sv]
// Package of the SQL column type classifier: types, keyword table and kind codes.
// No dependencies; every module of the block imports it.
package sqltk_pkg;

    localparam int WIN_DEPTH = 8;
    localparam int KW_MAXLEN = WIN_DEPTH + 1;
    localparam int NUM_KW    = 22;

    typedef logic [7:0]                 byte_t;
    typedef logic [3:0]                 kind_t;
    typedef logic [NUM_KW-1:0]          kw_vec_t;
    typedef logic [3:0]                 kw_len_t;
    typedef logic [KW_MAXLEN*8-1:0]     kw_text_t;
    typedef logic [KW_MAXLEN-1:0][7:0]  window_t;

    // Control that the top level hands to every window cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    localparam kind_t KIND_UNKNOWN  = 4'd0;
    localparam kind_t KIND_BOOLEAN  = 4'd1;
    localparam kind_t KIND_INTEGER  = 4'd2;
    localparam kind_t KIND_JSON     = 4'd3;
    localparam kind_t KIND_DATETIME = 4'd4;
    localparam kind_t KIND_DATE     = 4'd5;
    localparam kind_t KIND_BLOB     = 4'd6;
    localparam kind_t KIND_TEXT     = 4'd7;
    localparam kind_t KIND_REAL     = 4'd8;

    localparam byte_t CHAR_OPEN_PAREN = 8'h28;
    localparam byte_t CHAR_UPPER_A    = 8'h41;
    localparam byte_t CHAR_UPPER_Z    = 8'h5A;
    localparam byte_t CASE_OFFSET     = 8'h20;

    // Keyword text, right aligned: the last letter sits in the low byte.
    localparam kw_text_t [NUM_KW-1:0] KW_TEXT = '{
        0: "bool",     1: "int",       2: "serial",  3: "json",
        4: "datetime", 5: "timestamp", 6: "date",    7: "year",
        8: "time",     9: "blob",      10: "binary", 11: "bytea",
        12: "char",    13: "text",     14: "enum",   15: "set",
        16: "clob",    17: "real",     18: "float",  19: "double",
        20: "decimal", 21: "numeric"
    };

    localparam kw_len_t [NUM_KW-1:0] KW_LEN = '{
        0: 4'd4,  1: 4'd3,  2: 4'd6,  3: 4'd4,  4: 4'd8,  5: 4'd9,
        6: 4'd4,  7: 4'd4,  8: 4'd4,  9: 4'd4,  10: 4'd6, 11: 4'd5,
        12: 4'd4, 13: 4'd4, 14: 4'd4, 15: 4'd3, 16: 4'd4, 17: 4'd4,
        18: 4'd5, 19: 4'd6, 20: 4'd7, 21: 4'd7
    };

    // Priority pick over the found flags.
    function automatic kind_t pick_kind(input kw_vec_t s);
        kind_t k;
        if (s[0])              k = KIND_BOOLEAN;
        else if (|s[2:1])      k = KIND_INTEGER;
        else if (s[3])         k = KIND_JSON;
        else if (|s[5:4])      k = KIND_DATETIME;
        else if (|s[7:6])      k = KIND_DATE;
        else if (s[8])         k = KIND_DATETIME;
        else if (|s[11:9])     k = KIND_BLOB;
        else if (|s[16:12])    k = KIND_TEXT;
        else if (|s[21:17])    k = KIND_REAL;
        else                   k = KIND_UNKNOWN;
        return k;
    endfunction

endpackage

[src/sqltk_cell.sv]
// One stage of the byte window: holds a byte and passes it to the next stage.
// Depends on sqltk_pkg.
module sqltk_cell
    import sqltk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  byte_t      din,
    output byte_t      dout
);

    byte_t byte_reg;
    byte_t byte_next;

    // Clear wins over shift; otherwise hold.
    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.shift)
        begin
            byte_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign dout = byte_reg;

endmodule

[src/sqltk_match.sv]
// Keyword compare over the byte window plus the incoming byte.
// Depends on sqltk_pkg; purely combinational.
module sqltk_match
    import sqltk_pkg::*;
(
    input  window_t win,
    output kw_vec_t hits
);

    // Each keyword is compared against the newest bytes, last letter first.
    always_comb
    begin
        for (int k = 0; k < NUM_KW; k++)
        begin
            hits[k] = 1'b1;
            for (int i = 0; i < KW_MAXLEN; i++)
            begin
                if ((4'(i) < KW_LEN[k]) && (win[i] != KW_TEXT[k][8*i +: 8]))
                begin
                    hits[k] = 1'b0;
                end
            end
        end
    end

endmodule

[src/sql_type_keyword_classifier.sv]
// Top level of the SQL column type classifier.
// Depends on sqltk_pkg, sqltk_cell, sqltk_match and assert_macros.svh.
//
// Use:
//   The byte channel (byte_valid, byte_stall, type_byte, is_last) carries the
//   declared type text, one word per cycle while byte_stall is low, with is_last
//   on its final byte. Letters are folded to lower case; from the first '(' on,
//   bytes are not matched. The kind channel (kind_valid, kind_stall, kind)
//   returns one word per text, holding the kind code of the package.
//   Throughput is one byte per cycle while byte_stall is low. The kind word
//   appears in the cycle after the last byte is accepted; the keyword compare
//   of the new byte against the window of eight cells and the priority pick are
//   combinational. The next text may start in the cycle right after a last byte.
//   The kind is held in an output register. While it waits under kind_stall,
//   byte_stall is raised, so a new byte is taken once the kind leaves.
//   Reset clears the window, the found flags, the parenthesis flag and the
//   output register; the block takes bytes as soon as reset is released.
`include "assert_macros.svh"

module sql_type_keyword_classifier
    import sqltk_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  byte_valid,
    output logic  byte_stall,
    input  byte_t type_byte,
    input  logic  is_last,
    output logic  kind_valid,
    input  logic  kind_stall,
    output kind_t kind
);

    logic       byte_acc;
    logic       take;
    byte_t      folded;
    cell_ctrl_t ctrl;
    window_t    win;
    kw_vec_t    hits;
    kw_vec_t    seen_reg;
    kw_vec_t    seen_next;
    kw_vec_t    seen_all;
    logic       paren_reg;
    logic       paren_next;
    logic       kind_valid_reg;
    logic       kind_valid_next;
    kind_t      kind_reg;
    kind_t      kind_next;

    // Handshake: stall only while a kind word waits.
    assign byte_stall = kind_valid_reg && kind_stall;
    assign byte_acc   = byte_valid && !byte_stall;

    // Case folding of ASCII capitals.
    always_comb
    begin
        folded = type_byte;
        if (type_byte inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})
        begin
            folded = type_byte + CASE_OFFSET;
        end
    end

    assign take       = byte_acc && !paren_reg && (type_byte != CHAR_OPEN_PAREN);
    assign ctrl.shift = take;
    assign ctrl.clear = byte_acc && is_last;

    // Window: the new byte and the chain of cells, newest first.
    assign win[0] = folded;

    genvar g;
    generate
        for (g = 0; g < WIN_DEPTH; g++)
        begin : g_cell
            sqltk_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .din   (win[g]),
                .dout  (win[g+1])
            );
        end
    endgenerate

    sqltk_match u_match (
        .win  (win),
        .hits (hits)
    );

    // Found flags and parenthesis flag; both clear after a last byte.
    always_comb
    begin
        seen_all   = take ? (seen_reg | hits) : seen_reg;
        seen_next  = seen_all;
        paren_next = paren_reg;
        if (byte_acc && !paren_reg && (type_byte == CHAR_OPEN_PAREN))
        begin
            paren_next = 1'b1;
        end
        if (byte_acc && is_last)
        begin
            seen_next  = '0;
            paren_next = 1'b0;
        end
    end

    // Output register of the kind channel.
    always_comb
    begin
        kind_valid_next = kind_valid_reg;
        kind_next       = kind_reg;
        if (byte_acc && is_last)
        begin
            kind_valid_next = 1'b1;
            kind_next       = pick_kind(seen_all);
        end
        else if (!kind_stall)
        begin
            kind_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            paren_reg      <= 1'b0;
            kind_valid_reg <= 1'b0;
            kind_reg       <= KIND_UNKNOWN;
        end
        else
        begin
            seen_reg       <= seen_next;
            paren_reg      <= paren_next;
            kind_valid_reg <= kind_valid_next;
            kind_reg       <= kind_next;
        end
    end

    assign kind_valid = kind_valid_reg;
    assign kind       = kind_reg;

    // A last byte always yields a kind word and leaves the state cleared.
    `ASSERT_CLKD(a_last_gives_kind, byte_acc && is_last |=> kind_valid_reg,
        "last byte produced no kind word")
    `ASSERT_CLKD(a_last_clears, byte_acc && is_last |=> (seen_reg == '0) && !paren_reg
        && (win[1] == '0), "state not cleared after last byte")
    // Once past the parenthesis the window and found flags freeze until the end.
    `ASSERT_CLKD(a_paren_freezes, paren_reg && !(byte_acc && is_last) |=>
        $stable(win[WIN_DEPTH:1]) && $stable(seen_reg), "matching went on past the parenthesis")
    `ASSERT_ALWAYS(a_kind_range, kind_valid_reg |-> kind_reg <= KIND_REAL,
        "kind code out of range")

endmodule

[tb/sql_type_keyword_classifier_tb.sv]
// Self-checking testbench for sql_type_keyword_classifier: feeds type texts a
// word at a time and checks every kind word against a local predictor.
// Depends on sqltk_pkg and the RTL of the classifier.
`timescale 1ns / 1ps

module sql_type_keyword_classifier_tb
    import sqltk_pkg::*;
();

    localparam int HIST_DEPTH   = 8;
    localparam int RANDOM_BYTES = 700;
    localparam int QUIET_FROM   = 600;

    // Keyword groups in the order in which they win.
    typedef enum int {
        RANK_BOOL, RANK_INT, RANK_JSON, RANK_STAMP, RANK_DATE,
        RANK_TIME, RANK_BLOB, RANK_TEXT, RANK_REAL, RANK_COUNT
    } kw_rank_t;

    // Predicts the kind of each type text and checks the kind words in order.
    class kind_scoreboard;
        string    kw_txt[$];
        kw_rank_t kw_rank[$];
        byte_t    hist[HIST_DEPTH];
        bit [RANK_COUNT-1:0] rank_seen;
        bit       after_paren;
        kind_t    pending[$];
        int       fails;

        function void learn(string txt, kw_rank_t rank);
            kw_txt  = {kw_txt, txt};
            kw_rank = {kw_rank, rank};
        endfunction

        function void clear();
            foreach (hist[i])
                hist[i] = '0;
            rank_seen   = '0;
            after_paren = 1'b0;
        endfunction

        function new();
            fails = 0;
            learn("bool", RANK_BOOL);       learn("int", RANK_INT);
            learn("serial", RANK_INT);      learn("json", RANK_JSON);
            learn("datetime", RANK_STAMP);  learn("timestamp", RANK_STAMP);
            learn("date", RANK_DATE);       learn("year", RANK_DATE);
            learn("time", RANK_TIME);       learn("blob", RANK_BLOB);
            learn("binary", RANK_BLOB);     learn("bytea", RANK_BLOB);
            learn("char", RANK_TEXT);       learn("text", RANK_TEXT);
            learn("enum", RANK_TEXT);       learn("set", RANK_TEXT);
            learn("clob", RANK_TEXT);       learn("real", RANK_REAL);
            learn("float", RANK_REAL);      learn("double", RANK_REAL);
            learn("decimal", RANK_REAL);    learn("numeric", RANK_REAL);
            clear();
        endfunction

        // Folds one byte, matches every keyword ending at it, then shifts it in.
        function void absorb(byte_t b);
            byte_t w[HIST_DEPTH+1];
            int    len;
            bit    hit;
            w[0] = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? byte_t'(b + CASE_OFFSET) : b;
            for (int i = 0; i < HIST_DEPTH; i++)
                w[i+1] = hist[i];
            foreach (kw_txt[k])
            begin
                len = kw_txt[k].len();
                hit = 1'b1;
                for (int i = 0; i < len; i++)
                    if (w[i] != byte_t'(kw_txt[k][len-1-i]))
                        hit = 1'b0;
                if (hit)
                    rank_seen[kw_rank[k]] = 1'b1;
            end
            for (int i = HIST_DEPTH - 1; i > 0; i--)
                hist[i] = hist[i-1];
            hist[0] = w[0];
        endfunction

        function kind_t rank_kind(kw_rank_t r);
            case (r)
                RANK_BOOL:  return KIND_BOOLEAN;
                RANK_INT:   return KIND_INTEGER;
                RANK_JSON:  return KIND_JSON;
                RANK_STAMP: return KIND_DATETIME;
                RANK_DATE:  return KIND_DATE;
                RANK_TIME:  return KIND_DATETIME;
                RANK_BLOB:  return KIND_BLOB;
                RANK_TEXT:  return KIND_TEXT;
                RANK_REAL:  return KIND_REAL;
                default:    return KIND_UNKNOWN;
            endcase
        endfunction

        function kind_t winning_kind();
            for (int r = 0; r < RANK_COUNT; r++)
                if (rank_seen[r])
                    return rank_kind(kw_rank_t'(r));
            return KIND_UNKNOWN;
        endfunction

        // Called for every accepted byte word.
        function void note_byte(byte_t b, logic last);
            if (!after_paren)
            begin
                if (b == CHAR_OPEN_PAREN)
                    after_paren = 1'b1;
                else
                    absorb(b);
            end
            if (last)
            begin
                pending = {pending, winning_kind()};
                clear();
            end
        endfunction

        function void flag(string msg);
            fails++;
            if (fails <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        // Called for every accepted kind word.
        function void check_kind(kind_t got);
            kind_t want;
            if (pending.size() == 0)
            begin
                flag($sformatf("kind %0d arrived with no text pending", got));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
                flag($sformatf("kind mismatch: expected %0d, got %0d", want, got));
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    logic  byte_valid;
    logic  byte_stall;
    byte_t type_byte;
    logic  is_last;
    logic  kind_valid;
    logic  kind_stall = 1'b0;
    kind_t kind;

    kind_scoreboard sb;
    byte_t text_bytes[$];
    int    bytes_sent = 0;
    bit    quiet_tail = 1'b0;
    int    stall_left = 0;

    sql_type_keyword_classifier dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .type_byte  (type_byte),
        .is_last    (is_last),
        .kind_valid (kind_valid),
        .kind_stall (kind_stall),
        .kind       (kind)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Both channels are observed at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (kind_valid && !kind_stall)
                sb.check_kind(kind);
            if (byte_valid && !byte_stall)
                sb.note_byte(type_byte, is_last);
        end
    end

    // Back-pressure on the kind channel comes in random bursts.
    always @(negedge clk)
    begin
        if (!rst_n || quiet_tail)
            kind_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            kind_stall <= 1'b1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 6) - 1;
            kind_stall <= 1'b1;
        end
        else
            kind_stall <= 1'b0;
    end

    // Sends one byte word; starts and ends at a falling edge.
    task automatic send_byte(input byte_t b, input logic last);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        byte_valid <= 1'b1;
        type_byte  <= b;
        is_last    <= last;
        do
            @(posedge clk);
        while (byte_stall);
        bytes_sent++;
        if (bytes_sent >= QUIET_FROM)
            quiet_tail = 1'b1;
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text_bytes[i])
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        text_bytes.delete();
    endtask

    // Appends one byte to the text being built.
    function automatic void add_byte(input byte_t c);
        text_bytes = {text_bytes, c};
    endfunction

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(byte_t'(s[i]));
        send_text();
    endtask

    // Appends a keyword in random letter case, optionally cut short.
    task automatic push_keyword(input string w, input bit cut);
        byte_t c;
        for (int i = 0; i < w.len() - cut; i++)
        begin
            c = byte_t'(w[i]);
            if ($urandom_range(0, 1))
                c = c - CASE_OFFSET;
            add_byte(c);
        end
    endtask

    // Printable filler that never opens a parenthesis.
    task automatic push_filler();
        byte_t c;
        c = byte_t'($urandom_range(32, 126));
        add_byte(c == CHAR_OPEN_PAREN ? byte_t'(" ") : c);
    endtask

    // Mostly keyword-shaped texts with random content, the rest raw noise.
    task automatic build_random_text();
        string w;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 10))
                add_byte(($urandom_range(0, 7) == 0) ? CHAR_OPEN_PAREN
                                                     : byte_t'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                push_filler();
            w = sb.kw_txt[$urandom_range(0, sb.kw_txt.size() - 1)];
            push_keyword(w, $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 2) == 0)
            begin
                push_filler();
                w = sb.kw_txt[$urandom_range(0, sb.kw_txt.size() - 1)];
                push_keyword(w, 1'b0);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                add_byte(CHAR_OPEN_PAREN);
                repeat ($urandom_range(0, 4))
                    add_byte(byte_t'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 4) == 0)
                push_filler();
        end
    endtask

    initial
    begin
        sb         = new();
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        type_byte  <= '0;
        is_last    <= 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed texts: lone parenthesis, case folding and its edges,
        // keywords after a parenthesis, extreme byte values.
        send_string("(");
        send_string("BOOL");
        send_string("x(int)");
        add_byte(8'hFF);
        send_text();
        add_byte(8'h00);
        send_text();
        send_string("@AZ[\140az{");
        send_string("tImE");

        while (bytes_sent < RANDOM_BYTES)
        begin
            build_random_text();
            send_text();
        end
        byte_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/sqltk_pkg.sv
src/sqltk_cell.sv
src/sqltk_match.sv
src/sql_type_keyword_classifier.sv
tb/sql_type_keyword_classifier_tb.sv
